>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SPS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sps check failed");

// Next-cycle implication, disabled while reset is high.
`define SPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sps check failed");

`endif

>>> rtl/core/sps_pkg.sv
// Package for the streaming price statistics unit: sizes, codes, step list,
// state encoding and the command/status structs of the arithmetic unit.
// No dependencies.
package sps_pkg;

   localparam int MAX_SAMPLES  = 4096;
   localparam int WINDOW_DEPTH = 64;
   localparam int SAMPLE_BITS  = 24;
   localparam int RING_AW      = $clog2(WINDOW_DEPTH);
   localparam int COUNT_W      = 13;

   // input action codes
   localparam logic ACT_ADD   = 1'b0;
   localparam logic ACT_CLEAR = 1'b1;

   // csr register indexes
   localparam logic [1:0] CSR_SMA_PERIOD  = 2'd0;
   localparam logic [1:0] CSR_EMA_PERIOD  = 2'd1;
   localparam logic [1:0] CSR_STEPS_AHEAD = 2'd2;

   // iteration counts of the arithmetic unit
   localparam logic [7:0] MUL_ITERS   = 8'd4;
   localparam logic [7:0] SQRT_ITERS  = 8'd32;
   localparam logic [7:0] ALPHA_ITERS = 8'd18;
   localparam logic [7:0] SMA_ITERS   = 8'd31;
   localparam logic [7:0] MEAN_ITERS  = 8'd37;
   localparam logic [7:0] WIDE_ITERS  = 8'd88;

   localparam logic [63:0] SQRT_START_BIT = 64'h4000_0000_0000_0000;

   typedef enum logic [1:0] {
      AOP_MUL,
      AOP_DIV,
      AOP_SQRT
   } aop_type;

   typedef struct packed {
      aop_type      op;
      logic [127:0] opa;
      logic [63:0]  opb;
      logic [7:0]   iters;
   } arith_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } arith_stat_type;

   // microsequence of one item
   typedef enum logic [4:0] {
      K_SQ, K_WP, K_II, K_ALPHA, K_EMA,
      K_RING, K_SMAD, K_MEAN,
      K_NSQ, K_SS, K_NN, K_VDIV, K_SQRT,
      K_NSII, K_SISI, K_NW, K_SIS, K_NM, K_A, K_B, K_ND, K_PDIV
   } step_type;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_APPLY = 6'b000010,
      ST_ISSUE = 6'b000100,
      ST_WAIT  = 6'b001000,
      ST_RING  = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

endpackage

>>> rtl/core/sps_if.sv
// Valid/ready channel interfaces of the streaming price statistics unit.
// Depends on sps_pkg.
interface sps_req_if;
   logic                           valid;
   logic                           ready;
   logic                           action;
   logic [sps_pkg::SAMPLE_BITS-1:0] price;

   modport source (output valid, action, price, input ready);
   modport sink   (input valid, action, price, output ready);
endinterface

interface sps_rsp_if;
   logic        valid;
   logic        ready;
   logic        accepted;
   logic [31:0] prediction;
   logic [23:0] moving_average;
   logic [23:0] exp_average;
   logic [23:0] volatility;
   logic [23:0] min_price;
   logic [23:0] max_price;
   logic [23:0] mean_price;

   modport source (output valid, accepted, prediction, moving_average, exp_average,
                   volatility, min_price, max_price, mean_price, input ready);
   modport sink   (input valid, accepted, prediction, moving_average, exp_average,
                   volatility, min_price, max_price, mean_price, output ready);
endinterface

>>> rtl/core/sps_arith.sv
// Shared multi-cycle arithmetic unit: 64x16-per-cycle multiplier, restoring
// divider (one quotient bit per cycle) and integer square root. Uses sps_pkg.
module sps_arith (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  sps_pkg::arith_cmd_type cmd,
   output sps_pkg::arith_stat_type stat,
   output logic [127:0]           result
);
   import sps_pkg::*;

   aop_type      op_ff;
   logic [127:0] acc_ff;
   logic [127:0] opa_ff;
   logic [63:0]  opb_ff;
   logic [64:0]  rem_ff;
   logic [7:0]   cnt_ff;
   logic         busy_ff;
   logic         done_ff;

   logic [79:0]  mul_part;
   logic [127:0] mul_acc;
   logic [64:0]  div_shift;
   logic         div_ge;
   logic [63:0]  sq_trial;
   logic         sq_ge;
   logic         load;

   assign load      = start && !busy_ff;
   assign mul_part  = opa_ff[63:0] * opb_ff[63:48];
   assign mul_acc   = {acc_ff[111:0], 16'd0} + {48'd0, mul_part};
   assign div_shift = {rem_ff[63:0], opa_ff[127]};
   assign div_ge    = (div_shift >= {1'b0, opb_ff}) && (opb_ff != 64'd0);
   assign sq_trial  = acc_ff[63:0] + opb_ff;
   assign sq_ge     = opa_ff[63:0] >= sq_trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 8'd0;
      end else begin
         done_ff <= 1'b0;
         if (load) begin
            busy_ff <= 1'b1;
            cnt_ff  <= cmd.iters;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 8'd1;
            if (cnt_ff == 8'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         op_ff  <= cmd.op;
         opa_ff <= cmd.opa;
         opb_ff <= cmd.opb;
         acc_ff <= '0;
         rem_ff <= '0;
      end else if (busy_ff) begin
         case (op_ff)
            AOP_MUL: begin
               acc_ff <= mul_acc;
               opb_ff <= opb_ff << 16;
            end
            AOP_DIV: begin
               rem_ff <= div_ge ? div_shift - {1'b0, opb_ff} : div_shift;
               acc_ff <= {acc_ff[126:0], div_ge};
               opa_ff <= opa_ff << 1;
            end
            AOP_SQRT: begin
               if (sq_ge) begin
                  opa_ff[63:0] <= opa_ff[63:0] - sq_trial;
                  acc_ff       <= {64'd0, (acc_ff[63:0] >> 1) + opb_ff};
               end else begin
                  acc_ff <= {64'd0, acc_ff[63:0] >> 1};
               end
               opb_ff <= opb_ff >> 2;
            end
            default: ;
         endcase
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign result    = acc_ff;

endmodule

>>> rtl/core/streaming_price_statistics_unit.sv
// Top level of the streaming price statistics unit: item sequencer, running
// sums, price ring memory and output register. Uses sps_pkg, sps_if, sps_arith.
//
//   channel   dir  handshake      payload
//   req_bus   in   valid/ready    action, price
//   rsp_bus   out  valid/ready    accepted, prediction, moving_average,
//                                 exp_average, volatility, min/max/mean_price
//   csr_*     in   csr_we         csr_index, csr_wdata (write only)
//
// One item at a time. A full add spends most of its time in the shared divider,
// one quotient bit per cycle (18+31+37+88+88 bits); the rest goes to the ring
// read, the multiplies, the root and the issue and handoff of each arithmetic step.
// Reset is synchronous, clears history and returns csr to their defaults;
// ring contents are not cleared, as an entry is only read after it was written.
// A finished result waits in the output register; the next item is accepted
// meanwhile and its result stalls in ST_OUT until the register frees.
module streaming_price_statistics_unit (
   input  logic            clock,
   input  logic            reset,
   sps_req_if.sink         req_bus,
   sps_rsp_if.source       rsp_bus,
   input  logic            csr_we,
   input  logic [1:0]      csr_index,
   input  logic [12:0]     csr_wdata
);
   import sps_pkg::*;

   // control
   state_type state_ff;
   step_type  step_ff;
   logic      rsp_valid_ff;

   // configuration
   logic [6:0]  sma_period_ff;
   logic [12:0] ema_period_ff;
   logic [11:0] steps_ahead_ff;

   // history
   logic [RING_AW-1:0]     ring_pos_ff;
   logic [COUNT_W-1:0]     count_ff;
   logic [36:0]            price_total_ff;
   logic [60:0]            square_total_ff;
   logic [47:0]            weighted_total_ff;
   logic [22:0]            index_total_ff;
   logic [34:0]            index_sq_total_ff;
   logic [39:0]            ema_ff;
   logic [SAMPLE_BITS-1:0] first_ff;
   logic [SAMPLE_BITS-1:0] lowest_ff;
   logic [SAMPLE_BITS-1:0] highest_ff;

   // current item
   logic                   action_ff;
   logic [SAMPLE_BITS-1:0] price_ff;
   logic [COUNT_W-1:0]     idx_ff;
   logic                   is_add_ff;
   logic                   accepted_ff;

   // ring memory and its reader
   logic [SAMPLE_BITS-1:0] ring_mem [WINDOW_DEPTH];
   logic [SAMPLE_BITS-1:0] ring_rd_ff;
   logic [RING_AW-1:0]     ring_raddr;
   logic [6:0]             ring_cnt_ff;
   logic                   rd_pend_ff;
   logic                   ring_we;
   logic                   ring_issue;
   logic                   ring_done;

   // working registers
   logic [30:0] window_ff;
   logic [16:0] alpha_ff;
   logic [87:0] t0_ff;
   logic [87:0] t1_ff;
   logic [63:0] t2_ff;
   logic [46:0] den_ff;
   logic [59:0] mag_ff;
   logic        negn_ff;
   logic [25:0] m_ff;
   logic [87:0] tot_ff;
   logic        neg_ff;
   logic [23:0] sma_ff;
   logic [23:0] mean_ff;
   logic [23:0] vol_ff;
   logic [31:0] pred_ff;

   // output register
   logic        out_accepted_ff;
   logic [31:0] out_prediction_ff;
   logic [23:0] out_sma_ff;
   logic [23:0] out_ema_ff;
   logic [23:0] out_vol_ff;
   logic [23:0] out_min_ff;
   logic [23:0] out_max_ff;
   logic [23:0] out_mean_ff;

   // arithmetic unit
   arith_cmd_type  arith_cmd;
   arith_stat_type arith_stat;
   logic [127:0]   sps_result;
   logic [127:0]   prod;
   logic           arith_start;

   // derived
   logic [6:0]   sma_per;
   logic [12:0]  ema_per;
   logic         n_ge_sma;
   logic         n_ge_two;
   logic         has_data;
   logic         step_en;
   logic         add_ok;
   logic         out_load;
   logic [39:0]  ema_target;
   logic         ema_up;
   logic [39:0]  ema_diff;
   logic [39:0]  ema_delta;
   logic         over;
   logic [31:0]  lim32;
   logic [31:0]  mag32;
   logic [31:0]  sat_pred;
   step_type     step_next;

   // zero periods act as one; long SMA periods clip to the ring depth
   assign sma_per = (sma_period_ff == 7'd0) ? 7'd1 :
                    (sma_period_ff > 7'(WINDOW_DEPTH)) ? 7'(WINDOW_DEPTH) : sma_period_ff;
   assign ema_per = (ema_period_ff == 13'd0) ? 13'd1 : ema_period_ff;

   assign n_ge_sma = count_ff >= {6'd0, sma_per};
   assign n_ge_two = count_ff >= 13'd2;
   assign has_data = count_ff != 13'd0;
   assign add_ok   = (action_ff == ACT_ADD) && (count_ff < 13'(MAX_SAMPLES));
   assign step_next = step_type'(step_ff + 5'd1);

   always_comb begin
      case (step_ff)
         K_SQ, K_WP, K_II: step_en = is_add_ff;
         K_ALPHA, K_EMA:   step_en = is_add_ff && (idx_ff != 13'd0);
         K_RING, K_SMAD:   step_en = n_ge_sma;
         K_MEAN:           step_en = has_data;
         default:          step_en = n_ge_two;
      endcase
   end

   assign ring_we     = (state_ff == ST_APPLY) && add_ok;
   assign ring_raddr  = ring_pos_ff - RING_AW'(1) - ring_cnt_ff[RING_AW-1:0];
   assign ring_issue  = (state_ff == ST_RING) && (ring_cnt_ff < sma_per);
   assign ring_done   = (state_ff == ST_RING) && (ring_cnt_ff == sma_per) && !rd_pend_ff;
   assign arith_start = (state_ff == ST_ISSUE) && step_en && (step_ff != K_RING);
   assign out_load    = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_bus.ready);

   // EMA moves toward price<<16 by |diff|*alpha>>16
   assign ema_target = {price_ff, 16'd0};
   assign ema_up     = ema_target >= ema_ff;
   assign ema_diff   = ema_up ? ema_target - ema_ff : ema_ff - ema_target;
   assign ema_delta  = prod[55:16];

   // regression quotient saturation
   assign prod  = sps_result;
   assign over  = neg_ff ? (prod > 128'h8000_0000) : (prod > 128'h7FFF_FFFF);
   assign lim32 = neg_ff ? 32'h8000_0000 : 32'h7FFF_FFFF;
   assign mag32 = over ? lim32 : prod[31:0];
   assign sat_pred = neg_ff ? 32'd0 - mag32 : mag32;

   // operands per step; dividends are left-aligned to their bit count
   always_comb begin
      arith_cmd.op    = AOP_MUL;
      arith_cmd.opa   = '0;
      arith_cmd.opb   = '0;
      arith_cmd.iters = MUL_ITERS;
      case (step_ff)
         K_SQ: begin
            arith_cmd.opa = 128'(price_ff);
            arith_cmd.opb = 64'(price_ff);
         end
         K_WP: begin
            arith_cmd.opa = 128'(idx_ff);
            arith_cmd.opb = 64'(price_ff);
         end
         K_II: begin
            arith_cmd.opa = 128'(idx_ff);
            arith_cmd.opb = 64'(idx_ff);
         end
         K_ALPHA: begin
            arith_cmd.op    = AOP_DIV;
            arith_cmd.opa   = {1'b1, 127'd0};
            arith_cmd.opb   = 64'(ema_per) + 64'd1;
            arith_cmd.iters = ALPHA_ITERS;
         end
         K_EMA: begin
            arith_cmd.opa = 128'(ema_diff);
            arith_cmd.opb = 64'(alpha_ff);
         end
         K_SMAD: begin
            arith_cmd.op    = AOP_DIV;
            arith_cmd.opa   = {window_ff, 97'd0};
            arith_cmd.opb   = 64'(sma_per);
            arith_cmd.iters = SMA_ITERS;
         end
         K_MEAN: begin
            arith_cmd.op    = AOP_DIV;
            arith_cmd.opa   = {price_total_ff, 91'd0};
            arith_cmd.opb   = 64'(count_ff);
            arith_cmd.iters = MEAN_ITERS;
         end
         K_NSQ: begin
            arith_cmd.opa = 128'(count_ff);
            arith_cmd.opb = 64'(square_total_ff);
         end
         K_SS: begin
            arith_cmd.opa = 128'(price_total_ff);
            arith_cmd.opb = 64'(price_total_ff);
         end
         K_NN: begin
            arith_cmd.opa = 128'(count_ff);
            arith_cmd.opb = 64'(count_ff);
         end
         K_VDIV: begin
            arith_cmd.op    = AOP_DIV;
            arith_cmd.opa   = {t0_ff - t1_ff, 40'd0};
            arith_cmd.opb   = t2_ff;
            arith_cmd.iters = WIDE_ITERS;
         end
         K_SQRT: begin
            arith_cmd.op    = AOP_SQRT;
            arith_cmd.opa   = 128'(t2_ff);
            arith_cmd.opb   = SQRT_START_BIT;
            arith_cmd.iters = SQRT_ITERS;
         end
         K_NSII: begin
            arith_cmd.opa = 128'(count_ff);
            arith_cmd.opb = 64'(index_sq_total_ff);
         end
         K_SISI: begin
            arith_cmd.opa = 128'(index_total_ff);
            arith_cmd.opb = 64'(index_total_ff);
         end
         K_NW: begin
            arith_cmd.opa = 128'(count_ff);
            arith_cmd.opb = 64'(weighted_total_ff);
         end
         K_SIS: begin
            arith_cmd.opa = 128'(index_total_ff);
            arith_cmd.opb = 64'(price_total_ff);
         end
         K_NM: begin
            arith_cmd.opa = 128'(count_ff);
            arith_cmd.opb = 64'(count_ff) + 64'(steps_ahead_ff);
         end
         K_A: begin
            arith_cmd.opa = 128'(price_total_ff);
            arith_cmd.opb = 64'(den_ff);
         end
         K_B: begin
            arith_cmd.opa = 128'(mag_ff);
            arith_cmd.opb = 64'(m_ff);
         end
         K_ND: begin
            arith_cmd.opa = 128'(count_ff);
            arith_cmd.opb = 64'(den_ff);
         end
         K_PDIV: begin
            arith_cmd.op    = AOP_DIV;
            arith_cmd.opa   = {tot_ff, 40'd0};
            arith_cmd.opb   = t2_ff;
            arith_cmd.iters = WIDE_ITERS;
         end
         default: ;
      endcase
   end

   sps_arith u_arith (
      .clock  (clock),
      .reset  (reset),
      .start  (arith_start),
      .cmd    (arith_cmd),
      .stat   (arith_stat),
      .result (sps_result)
   );

   // ring memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[ring_pos_ff] <= price_ff;
      end
      ring_rd_ff <= ring_mem[ring_raddr];
   end

   // control, configuration and history
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         step_ff           <= K_SQ;
         rsp_valid_ff      <= 1'b0;
         sma_period_ff     <= 7'd7;
         ema_period_ff     <= 13'd7;
         steps_ahead_ff    <= 12'd1;
         ring_pos_ff       <= '0;
         count_ff          <= '0;
         price_total_ff    <= '0;
         square_total_ff   <= '0;
         weighted_total_ff <= '0;
         index_total_ff    <= '0;
         index_sq_total_ff <= '0;
         ema_ff            <= '0;
         first_ff          <= '0;
         lowest_ff         <= '1;
         highest_ff        <= '0;
         is_add_ff         <= 1'b0;
         accepted_ff       <= 1'b0;
         ring_cnt_ff       <= '0;
         rd_pend_ff        <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SMA_PERIOD:  sma_period_ff  <= csr_wdata[6:0];
               CSR_EMA_PERIOD:  ema_period_ff  <= csr_wdata;
               CSR_STEPS_AHEAD: steps_ahead_ff <= csr_wdata[11:0];
               default: ;
            endcase
         end

         // a new beat loads as the old one leaves, so load wins
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_bus.valid) begin
                  state_ff <= ST_APPLY;
               end
            end
            ST_APPLY: begin
               step_ff  <= K_SQ;
               state_ff <= ST_ISSUE;
               if (action_ff == ACT_CLEAR) begin
                  ring_pos_ff       <= '0;
                  count_ff          <= '0;
                  price_total_ff    <= '0;
                  square_total_ff   <= '0;
                  weighted_total_ff <= '0;
                  index_total_ff    <= '0;
                  index_sq_total_ff <= '0;
                  ema_ff            <= '0;
                  first_ff          <= '0;
                  lowest_ff         <= '1;
                  highest_ff        <= '0;
                  is_add_ff         <= 1'b0;
                  accepted_ff       <= 1'b1;
               end else if (!add_ok) begin
                  // history full: sample refused, nothing moves
                  is_add_ff   <= 1'b0;
                  accepted_ff <= 1'b0;
               end else begin
                  is_add_ff      <= 1'b1;
                  accepted_ff    <= 1'b1;
                  ring_pos_ff    <= ring_pos_ff + RING_AW'(1);
                  count_ff       <= count_ff + 13'd1;
                  price_total_ff <= price_total_ff + 37'(price_ff);
                  index_total_ff <= index_total_ff + 23'(count_ff);
                  if (count_ff == 13'd0) begin
                     first_ff <= price_ff;
                     ema_ff   <= {price_ff, 16'd0};
                  end
                  if (price_ff < lowest_ff) begin
                     lowest_ff <= price_ff;
                  end
                  if (price_ff > highest_ff) begin
                     highest_ff <= price_ff;
                  end
               end
            end
            ST_ISSUE: begin
               if (!step_en) begin
                  if (step_ff == K_PDIV) begin
                     state_ff <= ST_OUT;
                  end else begin
                     step_ff <= step_next;
                  end
               end else if (step_ff == K_RING) begin
                  ring_cnt_ff <= '0;
                  rd_pend_ff  <= 1'b0;
                  state_ff    <= ST_RING;
               end else begin
                  state_ff <= ST_WAIT;
               end
            end
            ST_WAIT: begin
               if (arith_stat.done) begin
                  case (step_ff)
                     K_SQ:  square_total_ff   <= square_total_ff + prod[60:0];
                     K_WP:  weighted_total_ff <= weighted_total_ff + prod[47:0];
                     K_II:  index_sq_total_ff <= index_sq_total_ff + prod[34:0];
                     K_EMA: ema_ff <= ema_up ? ema_ff + ema_delta : ema_ff - ema_delta;
                     default: ;
                  endcase
                  if (step_ff == K_PDIV) begin
                     state_ff <= ST_OUT;
                  end else begin
                     step_ff  <= step_next;
                     state_ff <= ST_ISSUE;
                  end
               end
            end
            ST_RING: begin
               rd_pend_ff <= ring_issue;
               if (ring_issue) begin
                  ring_cnt_ff <= ring_cnt_ff + 7'd1;
               end
               if (ring_done) begin
                  step_ff  <= step_next;
                  state_ff <= ST_ISSUE;
               end
            end
            ST_OUT: begin
               if (out_load) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // item capture, working registers and output payload
   always_ff @(posedge clock) begin
      if ((state_ff == ST_IDLE) && req_bus.valid) begin
         action_ff <= req_bus.action;
         price_ff  <= req_bus.price;
      end
      if (state_ff == ST_APPLY) begin
         idx_ff <= count_ff;
      end
      if ((state_ff == ST_ISSUE) && (step_ff == K_RING)) begin
         window_ff <= '0;
      end
      if ((state_ff == ST_RING) && rd_pend_ff) begin
         window_ff <= window_ff + 31'(ring_rd_ff);
      end
      if ((state_ff == ST_WAIT) && arith_stat.done) begin
         case (step_ff)
            K_ALPHA: alpha_ff <= prod[16:0];
            K_SMAD:  sma_ff   <= prod[23:0];
            K_MEAN:  mean_ff  <= prod[23:0];
            K_NSQ:   t0_ff    <= prod[87:0];
            K_SS:    t1_ff    <= prod[87:0];
            K_NN:    t2_ff    <= prod[63:0];
            K_VDIV:  t2_ff    <= prod[63:0];
            K_SQRT:  vol_ff   <= prod[23:0];
            K_NSII:  t0_ff    <= prod[87:0];
            K_SISI:  den_ff   <= t0_ff[46:0] - prod[46:0];
            K_NW:    t0_ff    <= prod[87:0];
            K_SIS: begin
               negn_ff <= t0_ff < prod[87:0];
               mag_ff  <= (t0_ff < prod[87:0]) ? prod[59:0] - t0_ff[59:0]
                                               : t0_ff[59:0] - prod[59:0];
            end
            K_NM:    m_ff     <= prod[25:0] - 26'(index_total_ff);
            K_A:     t0_ff    <= prod[87:0];
            K_B: begin
               // sign of A + sign*B, kept as magnitude and sign
               if (!negn_ff) begin
                  tot_ff <= t0_ff + prod[87:0];
                  neg_ff <= 1'b0;
               end else if (t0_ff >= prod[87:0]) begin
                  tot_ff <= t0_ff - prod[87:0];
                  neg_ff <= 1'b0;
               end else begin
                  tot_ff <= prod[87:0] - t0_ff;
                  neg_ff <= 1'b1;
               end
            end
            K_ND:    t2_ff    <= prod[63:0];
            K_PDIV:  pred_ff  <= sat_pred;
            default: ;
         endcase
      end
      if (out_load) begin
         out_accepted_ff   <= accepted_ff;
         out_prediction_ff <= !has_data ? 32'd0 :
                              !n_ge_two ? 32'(first_ff) : pred_ff;
         out_sma_ff        <= n_ge_sma ? sma_ff : 24'd0;
         out_ema_ff        <= (count_ff >= ema_per) ? ema_ff[39:16] : 24'd0;
         out_vol_ff        <= n_ge_two ? vol_ff : 24'd0;
         out_min_ff        <= has_data ? lowest_ff : 24'd0;
         out_max_ff        <= has_data ? highest_ff : 24'd0;
         out_mean_ff       <= has_data ? mean_ff : 24'd0;
      end
   end

   assign req_bus.ready          = (state_ff == ST_IDLE);
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.accepted       = out_accepted_ff;
   assign rsp_bus.prediction     = out_prediction_ff;
   assign rsp_bus.moving_average = out_sma_ff;
   assign rsp_bus.exp_average    = out_ema_ff;
   assign rsp_bus.volatility     = out_vol_ff;
   assign rsp_bus.min_price      = out_min_ff;
   assign rsp_bus.max_price      = out_max_ff;
   assign rsp_bus.mean_price     = out_mean_ff;

endmodule

>>> rtl/core/sps_checker.sv
// Port-level checker for the streaming price statistics unit and its bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module sps_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_prediction,
   input logic [23:0] rsp_min,
   input logic [23:0] rsp_max,
   input logic [23:0] rsp_mean
);
   logic rsp_stall;
   logic mean_ok;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign mean_ok   = (rsp_min <= rsp_mean) && (rsp_mean <= rsp_max);

   // stalled beat stays valid, with prediction and mean stable
   `SPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid)
   `SPS_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_stall, $stable({rsp_prediction, rsp_mean}))
   // one item in flight: accepting closes the input
   `SPS_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   // mean lies between min and max
   `SPS_ASSERT_IMPL(a_mean_order, clock, reset, rsp_valid, mean_ok)
endmodule

bind streaming_price_statistics_unit sps_checker u_sps_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_prediction (rsp_bus.prediction),
   .rsp_min        (rsp_bus.min_price),
   .rsp_max        (rsp_bus.max_price),
   .rsp_mean       (rsp_bus.mean_price)
);
